[design/sp_fma_pkg.sv]
// ----------------------------------------------------------------------------
// sp_fma_pkg
// Shared types, constants and helpers for the binary32 fused multiply-add.
// ----------------------------------------------------------------------------
`default_nettype none

package sp_fma_pkg;

    // alignment / sum window width, bit 0 doubles as sticky
    localparam int WIN_W = 77;

    typedef logic [WIN_W-1:0]  window_t;
    typedef logic signed [11:0] exp_t;
    typedef logic [6:0]        shamt_t;

    localparam logic [31:0] QNAN_CANON = 32'h7FC0_0000;
    localparam logic [30:0] INF_MAG    = 31'h7F80_0000;
    localparam window_t     WIN_ONES   = '1;
    localparam exp_t        WIN_LAST   = 12'sd77;

    // right shift that folds every dropped bit into bit 0
    function automatic window_t shr_sticky(window_t x, shamt_t amt);
        window_t lost;
        window_t res;
        lost = x & ~(WIN_ONES << amt);
        res = x >> amt;
        res[0] = res[0] | (|lost);
        return res;
    endfunction

    // clamp a non-negative signed shift to the window size
    function automatic shamt_t clamp_shift(exp_t v);
        shamt_t r;
        if (v > WIN_LAST)
        begin
            r = 7'd77;
        end
        else
        begin
            r = v[6:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[design/single_precision_fused_multiply_add.sv]
// Binary32 fused multiply-add, x*y+z with one round-to-nearest-even.
// Throughput: one beat per cycle; the six-stage pipeline holds as a whole
// while the output beat is stalled.
// Reset: clears the stage valid bits only; datapath registers are not reset.
// ----------------------------------------------------------------------------
// single_precision_fused_multiply_add
// Multiply, align, add, leading-zero count, normalize, round and pack.
// ----------------------------------------------------------------------------
`default_nettype none

module single_precision_fused_multiply_add
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] multiplicand,
    input  wire logic [31:0] multiplier,
    input  wire logic [31:0] addend,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      fused_result
);
    import sp_fma_pkg::*;

    // pipeline advance
    logic adv;
    logic [5:0] vld_reg;

    assign adv       = !(vld_reg[5] && out_stall);
    assign in_stall  = !adv;
    assign out_valid = vld_reg[5];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    // ---------------- stage 1: unpack, multiply, specials ----------------
    logic [47:0] mp_reg;
    logic [23:0] mz_reg;
    exp_t        pe_reg, ze_reg;
    logic        sp1_reg, sz1_reg, spc1_reg;
    logic [31:0] spv1_reg;

    logic [7:0]  ex, ey, ez;
    logic [23:0] mx, my, mz;
    logic        nan_x, nan_y, nan_z, inf_x, inf_y, inf_z, zer_x, zer_y;
    logic        sp1, sz1, spc1, pzero;
    logic [31:0] spv1;
    exp_t        pe1, ze1;

    always_comb
    begin
        ex = multiplicand[30:23];
        ey = multiplier[30:23];
        ez = addend[30:23];
        mx = {ex != 8'd0, multiplicand[22:0]};
        my = {ey != 8'd0, multiplier[22:0]};
        mz = {ez != 8'd0, addend[22:0]};
        nan_x = (ex == 8'hFF) && (multiplicand[22:0] != 23'd0);
        nan_y = (ey == 8'hFF) && (multiplier[22:0] != 23'd0);
        nan_z = (ez == 8'hFF) && (addend[22:0] != 23'd0);
        inf_x = (ex == 8'hFF) && (multiplicand[22:0] == 23'd0);
        inf_y = (ey == 8'hFF) && (multiplier[22:0] == 23'd0);
        inf_z = (ez == 8'hFF) && (addend[22:0] == 23'd0);
        zer_x = (multiplicand[30:0] == 31'd0);
        zer_y = (multiplier[30:0] == 31'd0);
        sp1 = multiplicand[31] ^ multiplier[31];
        sz1 = addend[31];
        pzero = zer_x || zer_y;

        // lsb exponents, subnormals use exponent field one
        ze1 = exp_t'({4'd0, (ez == 8'd0) ? 8'd1 : ez}) - 12'sd150;
        pe1 = exp_t'({4'd0, (ex == 8'd0) ? 8'd1 : ex})
            + exp_t'({4'd0, (ey == 8'd0) ? 8'd1 : ey}) - 12'sd300;
        // zero product: line it up under the addend
        if (pzero)
        begin
            pe1 = ze1 - 12'sd49;
        end

        spc1 = 1'b1;
        spv1 = QNAN_CANON;
        if (nan_x || nan_y || nan_z)
        begin
            spv1 = QNAN_CANON;
        end
        else if ((inf_x || inf_y) && pzero)
        begin
            spv1 = QNAN_CANON;
        end
        else if ((inf_x || inf_y) && inf_z && (sp1 != sz1))
        begin
            spv1 = QNAN_CANON;
        end
        else if (inf_x || inf_y)
        begin
            spv1 = {sp1, INF_MAG};
        end
        else if (inf_z)
        begin
            spv1 = {sz1, INF_MAG};
        end
        else
        begin
            spc1 = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mp_reg   <= mx * my;
            mz_reg   <= mz;
            pe_reg   <= pe1;
            ze_reg   <= ze1;
            sp1_reg  <= sp1;
            sz1_reg  <= sz1;
            spc1_reg <= spc1;
            spv1_reg <= spv1;
        end
    end

    // ---------------- stage 2: align ----------------
    window_t     a2_reg, p2_reg;
    exp_t        base2_reg;
    logic        sp2_reg, sz2_reg, spc2_reg;
    logic [31:0] spv2_reg;

    exp_t    sh;
    window_t a_raw, p_raw, a2, p2;
    exp_t    base2;

    always_comb
    begin
        a_raw = window_t'(mz_reg) << 52;
        p_raw = window_t'(mp_reg) << 3;
        sh = pe_reg + 12'sd49 - ze_reg;
        if (sh >= 12'sd0)
        begin
            a2 = shr_sticky(a_raw, clamp_shift(sh));
            p2 = p_raw;
            base2 = pe_reg - 12'sd3;
        end
        else
        begin
            a2 = a_raw;
            p2 = shr_sticky(p_raw, clamp_shift(-sh));
            base2 = ze_reg - 12'sd52;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a2_reg    <= a2;
            p2_reg    <= p2;
            base2_reg <= base2;
            sp2_reg   <= sp1_reg;
            sz2_reg   <= sz1_reg;
            spc2_reg  <= spc1_reg;
            spv2_reg  <= spv1_reg;
        end
    end

    // ---------------- stage 3: add / subtract magnitudes ----------------
    window_t     m3_reg;
    exp_t        base3_reg;
    logic        sgn3_reg, effadd3_reg, sz3_reg, spc3_reg;
    logic [31:0] spv3_reg;

    window_t m3;
    logic    sgn3, effadd3;

    always_comb
    begin
        effadd3 = (sp2_reg == sz2_reg);
        if (effadd3)
        begin
            m3 = a2_reg + p2_reg;
            sgn3 = sz2_reg;
        end
        else if (a2_reg >= p2_reg)
        begin
            m3 = a2_reg - p2_reg;
            sgn3 = sz2_reg;
        end
        else
        begin
            m3 = p2_reg - a2_reg;
            sgn3 = sp2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m3_reg      <= m3;
            base3_reg   <= base2_reg;
            sgn3_reg    <= sgn3;
            effadd3_reg <= effadd3;
            sz3_reg     <= sz2_reg;
            spc3_reg    <= spc2_reg;
            spv3_reg    <= spv2_reg;
        end
    end

    // ---------------- stage 4: leading-zero count, zero result ----------------
    window_t     m4_reg;
    exp_t        base4_reg;
    logic [6:0]  lz4_reg;
    logic        sgn4_reg, spc4_reg;
    logic [31:0] spv4_reg;

    logic [6:0]  lz4;
    logic        zsgn, spc4;
    logic [31:0] spv4;

    always_comb
    begin
        lz4 = 7'd77;
        for (int i = 0; i < WIN_W; i++)
        begin
            if (m3_reg[i])
            begin
                lz4 = 7'(WIN_W - 1 - i);
            end
        end
        // exact zero: -0 only when both terms are -0
        zsgn = effadd3_reg && sz3_reg;
        spc4 = spc3_reg;
        spv4 = spv3_reg;
        if (!spc3_reg && (m3_reg == '0))
        begin
            spc4 = 1'b1;
            spv4 = {zsgn, 31'd0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m4_reg    <= m3_reg;
            base4_reg <= base3_reg;
            lz4_reg   <= lz4;
            sgn4_reg  <= sgn3_reg;
            spc4_reg  <= spc4;
            spv4_reg  <= spv4;
        end
    end

    // ---------------- stage 5: normalize / denormalize ----------------
    window_t     mn5_reg;
    exp_t        e5_reg;
    logic        sgn5_reg, spc5_reg;
    logic [31:0] spv5_reg;

    exp_t    nexp, s5, e5;
    window_t mn5;

    always_comb
    begin
        nexp = base4_reg + 12'sd203 - exp_t'({5'd0, lz4_reg});
        if (nexp >= 12'sd1)
        begin
            s5 = exp_t'({5'd0, lz4_reg});
            e5 = nexp;
        end
        else
        begin
            s5 = base4_reg + 12'sd202;
            e5 = 12'sd0;
        end
        if (s5 >= 12'sd0)
        begin
            mn5 = m4_reg << clamp_shift(s5);
        end
        else
        begin
            mn5 = shr_sticky(m4_reg, clamp_shift(-s5));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mn5_reg  <= mn5;
            e5_reg   <= e5;
            sgn5_reg <= sgn4_reg;
            spc5_reg <= spc4_reg;
            spv5_reg <= spv4_reg;
        end
    end

    // ---------------- stage 6: round and pack ----------------
    logic [31:0] res_reg;

    logic [23:0] mant;
    logic        grd, stk, inc;
    logic [30:0] packed_mag;
    logic [31:0] res6;

    always_comb
    begin
        mant = mn5_reg[76:53];
        grd  = mn5_reg[52];
        stk  = |mn5_reg[51:0];
        inc  = grd && (stk || mant[0]);
        packed_mag = {e5_reg[7:0], mant[22:0]} + 31'(inc);
        if (spc5_reg)
        begin
            res6 = spv5_reg;
        end
        else if ((e5_reg >= 12'sd255) || (packed_mag >= INF_MAG))
        begin
            res6 = {sgn5_reg, INF_MAG};
        end
        else
        begin
            res6 = {sgn5_reg, packed_mag};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= res6;
        end
    end

    assign fused_result = res_reg;

endmodule

`default_nettype wire
